// ===== hw/rtl/swerve_inverse_kinematics_unit_macros.svh =====
// assertion macros for the swerve inverse kinematics unit
// used by the top level only, no other dependencies
`ifndef SWERVE_INVERSE_KINEMATICS_UNIT_MACROS_SVH
`define SWERVE_INVERSE_KINEMATICS_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SIK_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SIK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sik_pkg.sv =====
// shared types, widths, register indexes and the cordic arctan table
// no dependencies
`default_nettype none

package sik_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    // wheel vector width (signed), speed magnitude width, angle width
    localparam int VW    = 50;
    localparam int MW    = 48;
    localparam int ANG_W = 16;
    localparam int REG_W = 32;

    // divider quotient widths and rounding constants
    localparam int SCALE_QW  = 32;
    localparam int OMEGA_QW  = 31;
    localparam int SAT_SHIFT = 15;
    localparam int HALF_SHIFT = 17;

    localparam logic [31:0] CORDIC_GAIN_INV = 32'h9B74EDA8;
    localparam logic [31:0] ROT_HALF_TURN   = 32'h80000000;
    localparam logic [31:0] ANG_ROUND       = 32'h00008000;
    localparam logic [15:0] QUARTER_TURN    = 16'd16384;
    localparam logic [15:0] THREE_QUARTER   = 16'd49152;
    localparam logic [15:0] HALF_TURN       = 16'h8000;

    // register indexes
    localparam logic [1:0] REG_CHASSIS_LENGTH   = 2'd0;
    localparam logic [1:0] REG_CHASSIS_WIDTH    = 2'd1;
    localparam logic [1:0] REG_WHEEL_RADIUS     = 2'd2;
    localparam logic [1:0] REG_MAX_LINEAR_SPEED = 2'd3;

    // register reset values
    localparam logic [31:0] LENGTH_RST    = 32'd65536;
    localparam logic [31:0] WIDTH_RST     = 32'd65536;
    localparam logic [31:0] RADIUS_RST    = 32'd6554;
    localparam logic [31:0] MAX_SPEED_RST = 32'd0;

    // one wheel in flight: rim speed as sign and magnitude, target angle
    typedef struct packed {
        logic             neg;
        logic [ANG_W-1:0] tgt;
        logic [MW-1:0]    mag;
    } lane_t;

    localparam int LANE_W = $bits(lane_t);

    // binary-angle arctan(2^-i), 2^32 per turn
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            24: val = 32'd41;
            25: val = 32'd20;
            26: val = 32'd10;
            27: val = 32'd5;
            28: val = 32'd3;
            29: val = 32'd1;
            30: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sik_cordic.sv =====
// pipelined vectoring cordic for one wheel: magnitude and binary angle
// depends on sik_pkg
`default_nettype none

module sik_cordic #(
    parameter int STAGES = sik_pkg::CORDIC_STAGES_DEF,
    parameter int SW     = sik_pkg::ANG_W
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [sik_pkg::VW-1:0]     x_in,
    input  wire logic signed [sik_pkg::VW-1:0]     y_in,
    input  wire logic [SW-1:0]                     side_in,
    output logic [sik_pkg::MW-1:0]                 mag_out,
    output logic [sik_pkg::ANG_W-1:0]              ang_out,
    output logic [SW-1:0]                          side_out
);

    localparam int VW = sik_pkg::VW;
    localparam int MW = sik_pkg::MW;

    logic signed [VW-1:0] x_reg    [STAGES+1];
    logic signed [VW-1:0] y_reg    [STAGES+1];
    logic [31:0]          z_reg    [STAGES+1];
    logic [SW-1:0]        side_reg [STAGES+1];
    logic signed [VW-1:0] x_next   [STAGES+1];
    logic signed [VW-1:0] y_next   [STAGES+1];
    logic [31:0]          z_next   [STAGES+1];
    logic [SW-1:0]        side_next[STAGES+1];
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    logic [63:0]   ph_reg;
    logic [63:0]   pl_reg;
    logic [31:0]   zm_reg;
    logic [SW-1:0] sm_reg;
    logic [MW-1:0] mag_reg;
    logic [31:0]   za_reg;
    logic [SW-1:0] sa_reg;
    logic [31:0]   zr;

    // pre-rotation into the right half plane, then one micro-rotation per stage
    always_comb begin
        if (x_in[VW-1]) begin
            x_next[0] = -x_in;
            y_next[0] = -y_in;
            z_next[0] = sik_pkg::ROT_HALF_TURN;
        end else begin
            x_next[0] = x_in;
            y_next[0] = y_in;
            z_next[0] = '0;
        end
        side_next[0] = side_in;
        dx = '0;
        dy = '0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!y_reg[i][VW-1]) begin
                x_next[i+1] = x_reg[i] + dx;
                y_next[i+1] = y_reg[i] - dy;
                z_next[i+1] = z_reg[i] + sik_pkg::atan_entry(i);
            end else begin
                x_next[i+1] = x_reg[i] - dx;
                y_next[i+1] = y_reg[i] + dy;
                z_next[i+1] = z_reg[i] - sik_pkg::atan_entry(i);
            end
            side_next[i+1] = side_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_next;
        end
    end

    // gain correction: two partial products, then their sum
    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg  <= 64'(x_reg[STAGES][VW-2:32]) * 64'(sik_pkg::CORDIC_GAIN_INV);
            pl_reg  <= 64'(x_reg[STAGES][31:0]) * 64'(sik_pkg::CORDIC_GAIN_INV);
            zm_reg  <= z_reg[STAGES];
            sm_reg  <= side_reg[STAGES];
            mag_reg <= ph_reg[MW-1:0] + MW'(pl_reg[63:32]);
            za_reg  <= zm_reg;
            sa_reg  <= sm_reg;
        end
    end

    // round the 32-bit angle to 16 bits
    assign zr       = za_reg + sik_pkg::ANG_ROUND;
    assign mag_out  = mag_reg;
    assign ang_out  = zr[31:16];
    assign side_out = sa_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sik_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on nothing but its parameters
`default_nettype none

module sik_div #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [QW-1:0] num_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [SW-1:0] side_in,
    output logic [QW-1:0]      quo_out,
    output logic [SW-1:0]      side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] num_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] num_next [QW];
    logic [DW-1:0] den_next [QW];
    logic [QW-1:0] quo_next [QW];
    logic [SW-1:0] side_next[QW];

    logic [DW-1:0] rem_src;
    logic [QW-1:0] num_src;
    logic [DW-1:0] den_src;
    logic [QW-1:0] quo_src;
    logic [SW-1:0] side_src;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // shift in the next numerator bit, subtract the divisor when it fits
    always_comb begin
        rem_src  = '0;
        num_src  = '0;
        den_src  = '0;
        quo_src  = '0;
        side_src = '0;
        trial    = '0;
        diff     = '0;
        ge       = 1'b0;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem_src  = rem_in;
                num_src  = num_in;
                den_src  = den_in;
                quo_src  = '0;
                side_src = side_in;
            end else begin
                rem_src  = rem_reg[k-1];
                num_src  = num_reg[k-1];
                den_src  = den_reg[k-1];
                quo_src  = quo_reg[k-1];
                side_src = side_reg[k-1];
            end
            trial = {rem_src, num_src[QW-1]};
            diff  = trial - {1'b0, den_src};
            ge    = (trial >= {1'b0, den_src});
            rem_next[k]  = ge ? diff[DW-1:0] : trial[DW-1:0];
            num_next[k]  = num_src << 1;
            den_next[k]  = den_src;
            quo_next[k]  = {quo_src[QW-2:0], ge};
            side_next[k] = side_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
            side_reg <= side_next;
        end
    end

    assign quo_out  = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/swerve_inverse_kinematics_unit.sv =====
// top level of the four-wheel swerve inverse kinematics pipeline
// depends on sik_pkg, sik_cordic, sik_div and the assertion macro header
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    cmd_vx, cmd_vy, cmd_wz, cur_angle_*
//   m_       out        m_valid / m_ready    status, omega_*, angle_*
//   cfg_     in         cfg_wr_en            cfg_addr, cfg_wdata
//
// one request per cycle while the pipeline advances; CORDIC_STAGES + 74 register
// stages through the half-product, wheel vector, cordic, flip, max, scale
// divider, scale multiply and omega divider stages plus the output register.
// the pipeline advances when its last stage is empty or the output register
// frees up, so bubbles drain while a result waits. synchronous active-low
// reset clears valid bits and the config registers.
`default_nettype none
`include "swerve_inverse_kinematics_unit_macros.svh"

module swerve_inverse_kinematics_unit #(
    parameter int CORDIC_STAGES = sik_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_cmd_vx,
    input  wire logic signed [31:0] s_cmd_vy,
    input  wire logic signed [31:0] s_cmd_wz,
    input  wire logic signed [15:0] s_cur_angle_fl,
    input  wire logic signed [15:0] s_cur_angle_fr,
    input  wire logic signed [15:0] s_cur_angle_rl,
    input  wire logic signed [15:0] s_cur_angle_rr,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_status,
    output logic signed [31:0]      m_omega_fl,
    output logic signed [31:0]      m_omega_fr,
    output logic signed [31:0]      m_omega_rl,
    output logic signed [31:0]      m_omega_rr,
    output logic signed [15:0]      m_angle_fl,
    output logic signed [15:0]      m_angle_fr,
    output logic signed [15:0]      m_angle_rl,
    output logic signed [15:0]      m_angle_rr
);

    localparam int VW     = sik_pkg::VW;
    localparam int MW     = sik_pkg::MW;
    localparam int LW     = sik_pkg::LANE_W;
    localparam int HS     = sik_pkg::HALF_SHIFT;
    localparam int SQW    = sik_pkg::SCALE_QW;
    localparam int OQW    = sik_pkg::OMEGA_QW;
    localparam int SAT    = sik_pkg::SAT_SHIFT;
    localparam int SSW    = 4 * LW + 1;
    localparam int OSW    = sik_pkg::ANG_W + 2;
    localparam int PIPE_LAT = 2 + (CORDIC_STAGES + 3) + 3 + SQW + 2 + OQW;

    // config registers
    logic [31:0] len_reg;
    logic [31:0] wid_reg;
    logic [31:0] rad_reg;
    logic [31:0] lim_reg;
    logic        invalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= sik_pkg::LENGTH_RST;
            wid_reg <= sik_pkg::WIDTH_RST;
            rad_reg <= sik_pkg::RADIUS_RST;
            lim_reg <= sik_pkg::MAX_SPEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sik_pkg::REG_CHASSIS_LENGTH:   len_reg <= cfg_wdata;
                sik_pkg::REG_CHASSIS_WIDTH:    wid_reg <= cfg_wdata;
                sik_pkg::REG_WHEEL_RADIUS:     rad_reg <= cfg_wdata;
                sik_pkg::REG_MAX_LINEAR_SPEED: lim_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign invalid = (len_reg == '0) || (wid_reg == '0) || (rad_reg == '0);

    // pipeline control
    logic                adv;
    logic [PIPE_LAT-1:0] vld_reg;
    logic                m_valid_reg;
    logic                vld_last;

    assign vld_last = vld_reg[PIPE_LAT-1];
    assign adv      = !vld_last || !m_valid_reg || m_ready;
    assign s_ready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    // stage 1: |wz| times half length and half width
    logic [31:0]   wz_abs;
    logic [63:0]   prod_l_next;
    logic [63:0]   prod_w_next;
    logic [63-HS:0] pl_reg;
    logic [63-HS:0] pw_reg;
    logic          wzneg_reg;
    logic [31:0]   vx_reg;
    logic [31:0]   vy_reg;
    logic [15:0]   cur1_reg [4];

    assign wz_abs      = s_cmd_wz[31] ? 32'(-s_cmd_wz) : 32'(s_cmd_wz);
    assign prod_l_next = 64'(wz_abs) * 64'(len_reg);
    assign prod_w_next = 64'(wz_abs) * 64'(wid_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pl_reg      <= prod_l_next[63:HS];
            pw_reg      <= prod_w_next[63:HS];
            wzneg_reg   <= s_cmd_wz[31];
            vx_reg      <= s_cmd_vx;
            vy_reg      <= s_cmd_vy;
            cur1_reg[0] <= s_cur_angle_fl;
            cur1_reg[1] <= s_cur_angle_fr;
            cur1_reg[2] <= s_cur_angle_rl;
            cur1_reg[3] <= s_cur_angle_rr;
        end
    end

    // stage 2: wheel velocity vectors
    logic signed [VW-1:0] tx;
    logic signed [VW-1:0] ty;
    logic signed [VW-1:0] vx_e;
    logic signed [VW-1:0] vy_e;
    logic signed [VW-1:0] vix_next [4];
    logic signed [VW-1:0] viy_next [4];
    logic signed [VW-1:0] vix_reg  [4];
    logic signed [VW-1:0] viy_reg  [4];
    logic [15:0]          cur2_reg [4];

    always_comb begin
        tx   = wzneg_reg ? -VW'(pl_reg) : VW'(pl_reg);
        ty   = wzneg_reg ? -VW'(pw_reg) : VW'(pw_reg);
        vx_e = {{(VW-32){vx_reg[31]}}, vx_reg};
        vy_e = {{(VW-32){vy_reg[31]}}, vy_reg};
        for (int k = 0; k < 4; k++) begin
            vix_next[k] = (k % 2 == 1) ? vx_e + ty : vx_e - ty;
            viy_next[k] = (k / 2 == 1) ? vy_e - tx : vy_e + tx;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vix_reg  <= vix_next;
            viy_reg  <= viy_next;
            cur2_reg <= cur1_reg;
        end
    end

    // cordic lanes
    logic [MW-1:0] mag_c [4];
    logic [15:0]   ang_c [4];
    logic [15:0]   cur_c [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        sik_cordic #(
            .STAGES (CORDIC_STAGES),
            .SW     (sik_pkg::ANG_W)
        ) u_cordic (
            .aclk     (aclk),
            .en       (adv),
            .x_in     (vix_reg[g]),
            .y_in     (viy_reg[g]),
            .side_in  (cur2_reg[g]),
            .mag_out  (mag_c[g]),
            .ang_out  (ang_c[g]),
            .side_out (cur_c[g])
        );
    end

    // flip stage: keep angle on zero speed, reverse when past a quarter turn
    sik_pkg::lane_t lane_f_next [4];
    sik_pkg::lane_t lane_f_reg  [4];
    logic [15:0]    tgt_sel;
    logic [15:0]    err;
    logic           flip;
    logic           nz;

    always_comb begin
        tgt_sel = '0;
        err     = '0;
        flip    = 1'b0;
        nz      = 1'b0;
        for (int k = 0; k < 4; k++) begin
            nz      = (mag_c[k] != '0);
            tgt_sel = nz ? ang_c[k] : cur_c[k];
            err     = tgt_sel - cur_c[k];
            flip    = (err > sik_pkg::QUARTER_TURN) && (err < sik_pkg::THREE_QUARTER);
            lane_f_next[k].neg = flip && nz;
            lane_f_next[k].tgt = flip ? tgt_sel + sik_pkg::HALF_TURN : tgt_sel;
            lane_f_next[k].mag = mag_c[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lane_f_reg <= lane_f_next;
        end
    end

    // largest rim speed over a two-level registered tree
    sik_pkg::lane_t lane_x1_reg [4];
    sik_pkg::lane_t lane_x2_reg [4];
    logic [MW-1:0]  max01_reg;
    logic [MW-1:0]  max23_reg;
    logic [MW-1:0]  maxabs_next;
    logic [MW-1:0]  maxabs_reg;
    logic           lim_on_reg;

    assign maxabs_next = (max01_reg > max23_reg) ? max01_reg : max23_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            lane_x1_reg <= lane_f_reg;
            max01_reg   <= (lane_f_reg[0].mag > lane_f_reg[1].mag) ?
                           lane_f_reg[0].mag : lane_f_reg[1].mag;
            max23_reg   <= (lane_f_reg[2].mag > lane_f_reg[3].mag) ?
                           lane_f_reg[2].mag : lane_f_reg[3].mag;
            lane_x2_reg <= lane_x1_reg;
            maxabs_reg  <= maxabs_next;
            lim_on_reg  <= (lim_reg != '0) && (maxabs_next > MW'(lim_reg));
        end
    end

    // common scale factor: limit * 2^32 / maxabs
    logic [SSW-1:0] sd_side_in;
    logic [SSW-1:0] sd_side_out;
    logic [SQW-1:0] scale;

    assign sd_side_in = {lim_on_reg, lane_x2_reg[3], lane_x2_reg[2],
                         lane_x2_reg[1], lane_x2_reg[0]};

    sik_div #(
        .DW (MW),
        .QW (SQW),
        .SW (SSW)
    ) u_scale_div (
        .aclk     (aclk),
        .en       (adv),
        .rem_in   (MW'(lim_reg)),
        .num_in   ('0),
        .den_in   (maxabs_reg),
        .side_in  (sd_side_in),
        .quo_out  (scale),
        .side_out (sd_side_out)
    );

    // scale multiply: high and low partial products, then the sum
    sik_pkg::lane_t lane_sd   [4];
    sik_pkg::lane_t lane_m1_reg [4];
    sik_pkg::lane_t lane_m2_next [4];
    sik_pkg::lane_t lane_m2_reg [4];
    logic [MW-1:0]  ph_reg  [4];
    logic [63:0]    plo_reg [4];
    logic           lim_m1_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lane_sd[k] = sd_side_out[k*LW +: LW];
            lane_m2_next[k] = lane_m1_reg[k];
            if (lim_m1_reg) begin
                lane_m2_next[k].mag = ph_reg[k] + MW'(plo_reg[k][63:32]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                ph_reg[k]  <= MW'(lane_sd[k].mag[MW-1:32]) * MW'(scale);
                plo_reg[k] <= 64'(lane_sd[k].mag[31:0]) * 64'(scale);
            end
            lane_m1_reg <= lane_sd;
            lim_m1_reg  <= sd_side_out[4*LW];
            lane_m2_reg <= lane_m2_next;
        end
    end

    // omega dividers: |s| * 2^16 / radius, 31 quotient bits
    logic [OQW-1:0] quo_o [4];
    logic [OSW-1:0] side_o [4];

    for (genvar g = 0; g < 4; g++) begin : g_omega
        logic           sat;
        logic [OSW-1:0] od_side_in;

        assign sat = lane_m2_reg[g].mag >= MW'({rad_reg, {SAT{1'b0}}});
        assign od_side_in = {lane_m2_reg[g].neg, sat, lane_m2_reg[g].tgt};

        sik_div #(
            .DW (32),
            .QW (OQW),
            .SW (OSW)
        ) u_omega_div (
            .aclk     (aclk),
            .en       (adv),
            .rem_in   (lane_m2_reg[g].mag[SAT+31:SAT]),
            .num_in   ({lane_m2_reg[g].mag[SAT-1:0], {(OQW-SAT){1'b0}}}),
            .den_in   (rad_reg),
            .side_in  (od_side_in),
            .quo_out  (quo_o[g]),
            .side_out (side_o[g])
        );
    end

    // output register: sign, saturation and invalid model
    logic [31:0] omega_next [4];
    logic [15:0] angle_next [4];
    logic [31:0] omega_reg  [4];
    logic [15:0] angle_reg  [4];
    logic        status_reg;
    logic [31:0] omag;

    always_comb begin
        omag = '0;
        for (int k = 0; k < 4; k++) begin
            omag = side_o[k][OSW-2] ? 32'h80000000 : {1'b0, quo_o[k]};
            if (invalid) begin
                omega_next[k] = '0;
                angle_next[k] = '0;
            end else begin
                if (side_o[k][OSW-1]) begin
                    omega_next[k] = -omag;
                end else if (side_o[k][OSW-2]) begin
                    omega_next[k] = 32'h7FFFFFFF;
                end else begin
                    omega_next[k] = omag;
                end
                angle_next[k] = side_o[k][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= vld_last;
        end
    end

    always_ff @(posedge aclk) begin
        if ((!m_valid_reg || m_ready) && vld_last) begin
            omega_reg  <= omega_next;
            angle_reg  <= angle_next;
            status_reg <= invalid;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_omega_fl = omega_reg[0];
    assign m_omega_fr = omega_reg[1];
    assign m_omega_rl = omega_reg[2];
    assign m_omega_rr = omega_reg[3];
    assign m_angle_fl = angle_reg[0];
    assign m_angle_fr = angle_reg[1];
    assign m_angle_rl = angle_reg[2];
    assign m_angle_rr = angle_reg[3];

    // checks
    logic inv_out;
    logic omega_zero;
    logic res_stuck;
    logic res_moves;

    assign inv_out    = m_valid && m_status;
    assign omega_zero = (m_omega_fl == '0) && (m_omega_fr == '0) &&
                        (m_omega_rl == '0) && (m_omega_rr == '0);
    assign res_stuck  = vld_last && m_valid && !m_ready;
    assign res_moves  = vld_last && (!m_valid || m_ready);

    `SIK_ASSERT_NOW(a_invalid_zero, aclk, aresetn, inv_out, omega_zero, "invalid result speed")
    `SIK_ASSERT_NOW(a_stall_blocks, aclk, aresetn, res_stuck, !s_ready, "input open in stall")
    `SIK_ASSERT_NEXT(a_last_drains, aclk, aresetn, res_moves, m_valid, "finished request lost")

endmodule

`default_nettype wire

// ===== tb/sv/swerve_inverse_kinematics_unit_tb.sv =====
// self-checking testbench for the four-wheel swerve inverse kinematics unit
// depends on sik_pkg and swerve_inverse_kinematics_unit; predicts results in-line
`timescale 1ns / 1ps
`default_nettype none

module swerve_inverse_kinematics_unit_tb;

    localparam int STAGES     = 16;
    localparam int LATENCY    = STAGES + 74;
    localparam int N_RANDOM   = 1000;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int RECV_HOLD_CYCLES = 2000;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] wz;
        logic [3:0][15:0]   cur;
    } cmd_t;

    typedef struct packed {
        logic               status;
        logic [3:0][31:0]   omega;
        logic [3:0][15:0]   angle;
    } wheel_set_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_cmd_vx = '0, s_cmd_vy = '0, s_cmd_wz = '0;
    logic signed [15:0] s_cur_angle_fl = '0, s_cur_angle_fr = '0;
    logic signed [15:0] s_cur_angle_rl = '0, s_cur_angle_rr = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_status;
    logic signed [31:0] m_omega_fl, m_omega_fr, m_omega_rl, m_omega_rr;
    logic signed [15:0] m_angle_fl, m_angle_fr, m_angle_rl, m_angle_rr;

    swerve_inverse_kinematics_unit #(.CORDIC_STAGES(STAGES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd_vx(s_cmd_vx), .s_cmd_vy(s_cmd_vy), .s_cmd_wz(s_cmd_wz),
        .s_cur_angle_fl(s_cur_angle_fl), .s_cur_angle_fr(s_cur_angle_fr),
        .s_cur_angle_rl(s_cur_angle_rl), .s_cur_angle_rr(s_cur_angle_rr),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_omega_fl(m_omega_fl), .m_omega_fr(m_omega_fr),
        .m_omega_rl(m_omega_rl), .m_omega_rr(m_omega_rr),
        .m_angle_fl(m_angle_fl), .m_angle_fr(m_angle_fr),
        .m_angle_rl(m_angle_rl), .m_angle_rr(m_angle_rr)
    );

    always #5 aclk = ~aclk;

    // predictor copy of the chassis registers
    logic [31:0] len_q = sik_pkg::LENGTH_RST, wid_q = sik_pkg::WIDTH_RST;
    logic [31:0] rad_q = sik_pkg::RADIUS_RST, vmax_q = sik_pkg::MAX_SPEED_RST;

    cmd_t       cmd_queue[$];
    wheel_set_t wheel_queue[$];
    int  n_mismatch = 0;
    int  n_results = 0;
    int  n_flips = 0;
    int  n_limited = 0;
    bit  sender_hold = 1'b0;
    bit  recv_hold_req = 1'b0;
    bit  recv_hold_done = 1'b0;
    int  recv_hold_cnt = 0;
    logic recv_hold;
    longint cycle_cnt = 0;

    // arithmetic shift right on 64-bit signed, floor
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // 64x32 multiply keeping bits above 2^32, done in pieces to avoid overflow
    function automatic logic [63:0] mul_hi32(logic [63:0] a, logic [63:0] c);
        logic [63:0] lo;
        lo = a[31:0] * c;
        return (a >> 32) * c + (lo >> 32);
    endfunction

    function automatic longint half_wz(longint w, logic [31:0] r);
        logic [63:0] m, t;
        m = (w < 0) ? -w : w;
        t = (m * r) >> sik_pkg::HALF_SHIFT;
        return (w < 0) ? -longint'(t) : longint'(t);
    endfunction

    // full wheel-set prediction for one chassis command
    function automatic wheel_set_t predict_wheels(cmd_t c);
        wheel_set_t r;
        longint tx, ty, vix, viy, x, y, dx, dy;
        longint spd[4];
        logic [31:0] z;
        logic [15:0] tgt, e, cur;
        logic [63:0] mag, maxabs, scale, a, q, rm, om;
        r = '0;
        maxabs = 0;
        if (len_q == 0 || wid_q == 0 || rad_q == 0) begin
            r.status = 1'b1;
            return r;
        end
        tx = half_wz(c.wz, len_q);
        ty = half_wz(c.wz, wid_q);
        for (int k = 0; k < 4; k++) begin
            vix = (k & 1) ? c.vx + ty : c.vx - ty;
            viy = (k & 2) ? c.vy - tx : c.vy + tx;
            cur = c.cur[k];
            x = vix; y = viy; z = 0;
            if (x < 0) begin
                x = -x; y = -y; z = sik_pkg::ROT_HALF_TURN;
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = shr_floor(y, i);
                dy = shr_floor(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; z += sik_pkg::atan_entry(i);
                end else begin
                    x -= dx; y += dy; z -= sik_pkg::atan_entry(i);
                end
            end
            mag = mul_hi32(x, {32'd0, sik_pkg::CORDIC_GAIN_INV});
            if (mag == 0) begin
                spd[k] = 0;
                tgt = cur;
            end else begin
                spd[k] = mag;
                tgt = (z + sik_pkg::ANG_ROUND) >> 16;
            end
            e = tgt - cur;
            if (e > sik_pkg::QUARTER_TURN && e < sik_pkg::THREE_QUARTER) begin
                tgt = tgt + sik_pkg::HALF_TURN;
                spd[k] = -spd[k];
                n_flips++;
            end
            r.angle[k] = tgt;
            a = (spd[k] < 0) ? -spd[k] : spd[k];
            if (a > maxabs) maxabs = a;
        end
        // common speed limiting
        if (vmax_q != 0 && maxabs > vmax_q) begin
            n_limited++;
            scale = ({32'd0, vmax_q} << 32) / maxabs;
            for (int k = 0; k < 4; k++) begin
                a = (spd[k] < 0) ? -spd[k] : spd[k];
                a = mul_hi32(a, scale);
                spd[k] = (spd[k] < 0) ? -longint'(a) : longint'(a);
            end
        end
        // divide by radius with saturation
        for (int k = 0; k < 4; k++) begin
            a = (spd[k] < 0) ? -spd[k] : spd[k];
            q = a / rad_q;
            rm = a % rad_q;
            if (q >= 64'h8000_0000) om = 64'h8000_0000;
            else begin
                om = (q << 16) + ((rm << 16) / rad_q);
                if (om > 64'h8000_0000) om = 64'h8000_0000;
            end
            if (spd[k] < 0) r.omega[k] = -om[31:0];
            else r.omega[k] = (om > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : om[31:0];
        end
        return r;
    endfunction

    // request driver
    int gap_left = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                wheel_queue.push_back(predict_wheels(cmd_queue.pop_front()));
                gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
                if (cmd_queue.size() != 0 && !sender_hold && $urandom_range(0, 3) == 0)
                    s_valid <= 1'b1;
                else
                    s_valid <= 1'b0;
            end else if (!s_valid && cmd_queue.size() != 0 && !sender_hold) begin
                if (gap_left == 0) s_valid <= 1'b1;
                else gap_left <= gap_left - 1;
            end
            if (cmd_queue.size() != 0) begin
                s_cmd_vx <= cmd_queue[0].vx;
                s_cmd_vy <= cmd_queue[0].vy;
                s_cmd_wz <= cmd_queue[0].wz;
                s_cur_angle_fl <= cmd_queue[0].cur[0];
                s_cur_angle_fr <= cmd_queue[0].cur[1];
                s_cur_angle_rl <= cmd_queue[0].cur[2];
                s_cur_angle_rr <= cmd_queue[0].cur[3];
            end
        end
    end

    // long receiver hold, counted here once the stimulus asks for it
    assign recv_hold = recv_hold_req && !recv_hold_done;

    always @(posedge aclk) begin
        if (recv_hold) begin
            recv_hold_cnt <= recv_hold_cnt + 1;
            if (recv_hold_cnt == RECV_HOLD_CYCLES - 1) recv_hold_done <= 1'b1;
        end
    end

    // result monitor with its own ready pattern
    int stall_left = 0;
    always @(posedge aclk) begin
        wheel_set_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.omega = {m_omega_rr, m_omega_rl, m_omega_fr, m_omega_fl};
                got.angle = {m_angle_rr, m_angle_rl, m_angle_fr, m_angle_fl};
                n_results++;
                if (wheel_queue.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected result %h", got);
                end else begin
                    want = wheel_queue.pop_front();
                    if (got.status !== want.status || got.omega !== want.omega ||
                        got.angle !== want.angle) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("mismatch status exp %0d got %0d", want.status,
                                     got.status);
                            for (int k = 0; k < 4; k++)
                                $display("  wheel %0d omega exp %h got %h angle exp %h got %h",
                                         k, want.omega[k], got.omega[k],
                                         want.angle[k], got.angle[k]);
                        end
                    end
                end
            end
            if (recv_hold) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready)
                    stall_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
            end
        end
    end

    // timeout watchdog
    always @(posedge aclk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout with %0d results pending", wheel_queue.size());
            $display("[swerve_inverse_kinematics_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_field(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
                                            : -$urandom_range(0, 32'h0004_0000);
            2: return $urandom_range(0, 1) ? $urandom_range(0, 64) : -$urandom_range(0, 64);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int m;
        m = $urandom_range(0, 9);
        m = (m < 5) ? 1 : (m < 7) ? 0 : (m < 9) ? 2 : 3;
        c.vx = rand_field(m);
        c.vy = rand_field($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : m);
        c.wz = rand_field($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : m);
        for (int k = 0; k < 4; k++) c.cur[k] = $urandom();
        return c;
    endfunction

    function automatic cmd_t mk_cmd(logic [31:0] vx, logic [31:0] vy, logic [31:0] wz,
                                    logic [15:0] a);
        cmd_t c;
        c.vx = vx; c.vy = vy; c.wz = wz;
        c.cur = {a, a, a, a};
        return c;
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_valid || wheel_queue.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // idle-time register write, predictor copy updated alongside
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            sik_pkg::REG_CHASSIS_LENGTH:   len_q = val;
            sik_pkg::REG_CHASSIS_WIDTH:    wid_q = val;
            sik_pkg::REG_WHEEL_RADIUS:     rad_q = val;
            sik_pkg::REG_MAX_LINEAR_SPEED: vmax_q = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) cmd_queue.push_back(rand_cmd());
    endtask

    // stimulus sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero command, pure axes, extremes, flips, reset geometry
        cmd_queue.push_back(mk_cmd(0, 0, 0, 16'h1234));
        cmd_queue.push_back(mk_cmd(32'h0001_0000, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(32'h0001_0000, 0, 0, 16'h8000));
        cmd_queue.push_back(mk_cmd(32'hFFFF_0000, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(0, 32'h0001_0000, 0, 16'h4000));
        cmd_queue.push_back(mk_cmd(0, 32'hFFFF_0000, 0, 16'h4000));
        cmd_queue.push_back(mk_cmd(0, 0, 32'h0001_0000, 16'h7FFF));
        cmd_queue.push_back(mk_cmd(0, 0, 32'hFFFF_0000, 16'hC000));
        cmd_queue.push_back(mk_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF));
        cmd_queue.push_back(mk_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000));
        cmd_queue.push_back(mk_cmd(1, 0, 0, 16'h4001));
        cmd_queue.push_back(mk_cmd(32'hFFFF_FFFF, 1, 1, 16'hBFFF));
        cmd_queue.push_back(mk_cmd(32'h0000_8000, 32'h0000_8000, 0, 16'hE000));
        wait_drained();

        // speed limiting, then invalid geometry for each register
        write_reg(sik_pkg::REG_MAX_LINEAR_SPEED, 32'h0000_8000);
        cmd_queue.push_back(mk_cmd(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 0));
        cmd_queue.push_back(mk_cmd(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 16'h8000));
        wait_drained();
        write_reg(sik_pkg::REG_CHASSIS_LENGTH, 0);
        cmd_queue.push_back(mk_cmd(32'h0001_0000, 0, 0, 0));
        wait_drained();
        write_reg(sik_pkg::REG_CHASSIS_LENGTH, sik_pkg::LENGTH_RST);
        write_reg(sik_pkg::REG_CHASSIS_WIDTH, 0);
        cmd_queue.push_back(mk_cmd(0, 32'h0001_0000, 0, 0));
        wait_drained();
        write_reg(sik_pkg::REG_CHASSIS_WIDTH, sik_pkg::WIDTH_RST);
        write_reg(sik_pkg::REG_WHEEL_RADIUS, 0);
        cmd_queue.push_back(mk_cmd(0, 0, 32'h0001_0000, 0));
        wait_drained();

        // random phases over several geometries, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(sik_pkg::REG_CHASSIS_LENGTH, sik_pkg::LENGTH_RST);
                    write_reg(sik_pkg::REG_CHASSIS_WIDTH, sik_pkg::WIDTH_RST);
                    write_reg(sik_pkg::REG_WHEEL_RADIUS, sik_pkg::RADIUS_RST);
                    write_reg(sik_pkg::REG_MAX_LINEAR_SPEED, 0);
                end
                1: begin
                    write_reg(sik_pkg::REG_CHASSIS_LENGTH, 32'hFFFF_FFFF);
                    write_reg(sik_pkg::REG_CHASSIS_WIDTH, 32'hFFFF_FFFF);
                    write_reg(sik_pkg::REG_WHEEL_RADIUS, 32'hFFFF_FFFF);
                    write_reg(sik_pkg::REG_MAX_LINEAR_SPEED, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(sik_pkg::REG_CHASSIS_LENGTH, 1);
                    write_reg(sik_pkg::REG_CHASSIS_WIDTH, 1);
                    write_reg(sik_pkg::REG_WHEEL_RADIUS, 1);
                    write_reg(sik_pkg::REG_MAX_LINEAR_SPEED, 1);
                end
                default: begin
                    write_reg(sik_pkg::REG_CHASSIS_LENGTH, $urandom_range(1, 32'h0004_0000));
                    write_reg(sik_pkg::REG_CHASSIS_WIDTH, $urandom_range(1, 32'h0004_0000));
                    write_reg(sik_pkg::REG_WHEEL_RADIUS,
                              $urandom_range(0, 7) == 0 ? $urandom() :
                              $urandom_range(1, 32'h0002_0000));
                    write_reg(sik_pkg::REG_MAX_LINEAR_SPEED,
                              $urandom_range(0, 2) == 0 ? 0 :
                              $urandom_range(0, 3) == 0 ? $urandom() :
                              $urandom_range(1, 32'h0004_0000));
                end
            endcase
            if (ph == 3) begin
                // receiver holds off long while requests keep coming
                recv_hold_req = 1'b1;
            end
            random_burst(N_RANDOM / 8);
            if (ph == 5) begin
                // sender pauses until every result is back, then resumes
                while (cmd_queue.size() > N_RANDOM / 16) @(posedge aclk);
                sender_hold = 1'b1;
                while (s_valid) @(posedge aclk);
                while (wheel_queue.size() != 0) @(posedge aclk);
                sender_hold = 1'b0;
            end
            wait_drained();
        end

        $display("covered %0d results, %0d wheel flips, %0d limited commands",
                 n_results, n_flips, n_limited);
        $display("geometry extremes, invalid model, stalls and backpressure exercised");
        if (n_mismatch == 0 && wheel_queue.size() == 0)
            $display("[swerve_inverse_kinematics_unit] OK");
        else
            $display("[swerve_inverse_kinematics_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
